// File: hw/rtl/radix_tree_map_assert.svh
// assertion macros for the radix tree map
`ifndef RADIX_TREE_MAP_ASSERT_SVH
`define RADIX_TREE_MAP_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define RTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radix tree map check failed");

// consequence holds in the cycle after the antecedent
`define RTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radix tree map check failed");

`endif

// File: hw/rtl/rtm_pkg.sv
// shared types and constants for the radix tree map
`timescale 1ns / 1ps

package rtm_pkg;

  localparam int NODE_COUNT  = 256;
  localparam int MAX_FANOUT  = 16;
  localparam int MAX_LEVELS  = 8;
  localparam int STORE_DEPTH = NODE_COUNT * MAX_FANOUT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int FREE_W      = $clog2(NODE_COUNT + 1);
  localparam int SLOT_W      = $clog2(MAX_FANOUT);
  localparam int DATA_W      = 32;
  localparam int KEY_W       = 32;
  localparam int LVL_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_LAST_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSETS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTHS     = 2'd2;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_PATH_MISSING = 2'd1;
  localparam logic [1:0] ST_LEAF_EMPTY   = 2'd2;
  localparam logic [1:0] ST_POOL_FULL    = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0] last_level;
    logic [47:0]      level_offsets;
    logic [23:0]      level_widths;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              busy;
    logic [FREE_W-1:0] free_count;
  } walk_stat_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_EVAL
  } ctrl_state_t;

endpackage

// File: hw/rtl/radix_tree_map.sv
// a walk visits k levels (1..8) from accept to the done strobe
// unused command: done in the cycle after accept; next item may start in the done cycle
// no new item is taken until the walk is done; each level needs one slot memory read
//   and one evaluate step through the single read port
// reset: busy stays high during a clearing pass over all 4096 slot memory words
// results are strobed for one cycle; the receiver cannot stall
`timescale 1ns / 1ps
`include "radix_tree_map_assert.svh"

module radix_tree_map import rtm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  ram_req_t          ram;
  logic [DATA_W-1:0] rdata;
  walk_stat_t        stat;
  logic              pool_spent;

  assign cfg_ready  = 1'b1;
  assign busy       = stat.busy;
  assign pool_spent = (stat.free_count == FREE_W'(NODE_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LAST_LEVEL: cfg.last_level    <= cfg_data[LVL_W-1:0];
        CFG_OFFSETS:    cfg.level_offsets <= cfg_data[47:0];
        CFG_WIDTHS:     cfg.level_widths  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  rtm_walk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (start),
    .req   (req),
    .done  (done),
    .rsp   (rsp),
    .ram   (ram),
    .rdata (rdata),
    .stat  (stat)
  );

  rtm_slot_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  `RTM_ASSERT_NOW(a_done_when_idle, done, !busy)
  `RTM_ASSERT_NEXT(a_walk_starts, start && !busy && (req.cmd != CMD_NOP), busy && !done)
  `RTM_ASSERT_NOW(a_error_no_value, done && (rsp.status != ST_OK), rsp.read_value == '0)
  `RTM_ASSERT_NOW(a_pool_full_count, done && (rsp.status == ST_POOL_FULL), pool_spent)

endmodule

// File: hw/rtl/rtm_slot_ram.sv
// single port write, single port read slot memory with registered read
`timescale 1ns / 1ps

module rtm_slot_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rtm_slot_pick.sv
// slot address of one tree level from the key field and the node number
`timescale 1ns / 1ps

module rtm_slot_pick import rtm_pkg::*; (
  input  cfg_t              cfg,
  input  logic [KEY_W-1:0]  key,
  input  logic [LVL_W-1:0]  lvl,
  input  logic [NODE_W-1:0] node,
  output logic [ADDR_W-1:0] addr
);

  logic [5:0]        off;
  logic [2:0]        w;
  logic [63:0]       shifted;
  logic [6:0]        field;
  logic [SLOT_W-1:0] idx;
  logic [ADDR_W:0]   slot_wide;

  always_comb begin
    off = cfg.level_offsets[lvl*6 +: 6];
    w   = cfg.level_widths[lvl*3 +: 3];
    if (w == 3'd0) begin
      w = 3'd1;
    end
    shifted   = {32'd0, key} >> off;
    field     = shifted[6:0] & 7'((8'd1 << w) - 8'd1);
    idx       = SLOT_W'(field % MAX_FANOUT);
    slot_wide = (ADDR_W+1)'(node) * (ADDR_W+1)'(MAX_FANOUT) + (ADDR_W+1)'(idx);
    if (slot_wide >= (ADDR_W+1)'(STORE_DEPTH)) begin
      addr = '0;
    end else begin
      addr = slot_wide[ADDR_W-1:0];
    end
  end

endmodule

// File: hw/rtl/rtm_walk_ctrl.sv
// tree walk sequencer: clearing pass, level reads, node allocation, leaf update
`timescale 1ns / 1ps

module rtm_walk_ctrl import rtm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              start,
  input  req_t              req,
  output logic              done,
  output rsp_t              rsp,
  output ram_req_t          ram,
  input  logic [DATA_W-1:0] rdata,
  output walk_stat_t        stat
);

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [FREE_W-1:0] free_cnt;
  req_t              req_q;
  logic [LVL_W-1:0]  lvl;
  logic [NODE_W-1:0] node;
  logic [ADDR_W-1:0] addr_pick;
  logic [LVL_W-1:0]  leaf_lvl;
  logic              at_leaf;
  logic              empty_slot;
  logic              pool_full;
  logic              finish;
  logic              busy;

  rtm_slot_pick u_pick (
    .cfg  (cfg),
    .key  (req_q.key),
    .lvl  (lvl),
    .node (node),
    .addr (addr_pick)
  );

  always_comb begin
    if ({1'b0, cfg.last_level} >= (LVL_W+1)'(MAX_LEVELS)) begin
      leaf_lvl = LVL_W'(MAX_LEVELS - 1);
    end else begin
      leaf_lvl = cfg.last_level;
    end
    at_leaf    = (lvl == leaf_lvl);
    empty_slot = (rdata == '0);
    pool_full  = (free_cnt >= FREE_W'(NODE_COUNT));
    finish     = at_leaf || (empty_slot && ((req_q.cmd != CMD_INSERT) || pool_full));
    busy       = (state != S_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && (req.cmd != CMD_NOP)) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: state_next = S_EVAL;
      S_EVAL: begin
        state_next = finish ? S_IDLE : S_LOOK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram.we    = 1'b0;
    ram.waddr = addr_pick;
    ram.wdata = '0;
    ram.raddr = addr_pick;
    unique case (state)
      S_CLEAR: begin
        ram.we    = 1'b1;
        ram.waddr = clr_addr;
      end
      S_EVAL: begin
        if (at_leaf) begin
          if (req_q.cmd == CMD_INSERT) begin
            ram.we    = 1'b1;
            ram.wdata = req_q.value;
          end else if (req_q.cmd == CMD_DELETE) begin
            ram.we = 1'b1;
          end
        end else if (empty_slot && (req_q.cmd == CMD_INSERT) && !pool_full) begin
          ram.we    = 1'b1;
          ram.wdata = DATA_W'(free_cnt);
        end
      end
      default: ;
    endcase
    stat.busy       = busy;
    stat.free_count = free_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      free_cnt <= FREE_W'(1);
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + ADDR_W'(1);
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            lvl   <= '0;
            node  <= '0;
            if (req.cmd == CMD_NOP) begin
              done           <= 1'b1;
              rsp.status     <= ST_OK;
              rsp.read_value <= '0;
            end
          end
        end
        S_LOOK: ;
        S_EVAL: begin
          if (at_leaf) begin
            done <= 1'b1;
            if (req_q.cmd == CMD_INSERT) begin
              rsp.status     <= ST_OK;
              rsp.read_value <= '0;
            end else begin
              rsp.status     <= empty_slot ? ST_LEAF_EMPTY : ST_OK;
              rsp.read_value <= rdata;
            end
          end else if (empty_slot) begin
            if (req_q.cmd != CMD_INSERT) begin
              done           <= 1'b1;
              rsp.status     <= ST_PATH_MISSING;
              rsp.read_value <= '0;
            end else if (pool_full) begin
              done           <= 1'b1;
              rsp.status     <= ST_POOL_FULL;
              rsp.read_value <= '0;
            end else begin
              node     <= free_cnt[NODE_W-1:0];
              free_cnt <= free_cnt + FREE_W'(1);
              lvl      <= lvl + LVL_W'(1);
            end
          end else begin
            if (rdata < DATA_W'(NODE_COUNT)) begin
              node <= rdata[NODE_W-1:0];
            end else begin
              node <= '0;
            end
            lvl <= lvl + LVL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
